>>> src/epot_pkg.sv
// ----------------------------------------------------------------------------
// epot_pkg: shared definitions for the expiring priority override table
// Sizes, codes and the structs that pass between the table cells and the
// top level.
// ----------------------------------------------------------------------------
package epot_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W      = $clog2(TABLE_DEPTH);
    localparam int RATE_W      = 16;
    localparam int DUR_W       = 16;
    localparam int PRIO_W      = 8;
    localparam int CNT_OUT_W   = 5;
    localparam int STAT_W      = 2;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_DEPTH - 1);

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO_DUR = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

    // 1.0 in Q4.12.
    localparam logic [RATE_W-1:0] NORMAL_RATE_RST = 16'd4096;

    typedef struct packed {
        logic [RATE_W-1:0]        rate;
        logic signed [PRIO_W-1:0] prio;
        logic [DUR_W-1:0]         remaining;
    } t_entry;

    typedef struct packed {
        logic                     found;
        logic signed [PRIO_W-1:0] prio;
        logic [RATE_W-1:0]        rate;
        logic [DUR_W-1:0]         soonest;
        logic [CNT_W-1:0]         count;
    } t_scan;

    typedef struct packed {
        logic tick;
        logic load;
        logic pack;
    } t_cell_cmd;

endpackage

>>> src/epot_in_if.sv
// ----------------------------------------------------------------------------
// epot_in_if: input channel of the override table
// Carries tick and request beats with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface epot_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [epot_pkg::RATE_W-1:0]       rate_value;
    logic [epot_pkg::DUR_W-1:0]        duration_ticks;
    logic signed [epot_pkg::PRIO_W-1:0] priority_level;

    modport source (
        output valid, operation, rate_value, duration_ticks, priority_level,
        input  ready
    );
    modport sink (
        input  valid, operation, rate_value, duration_ticks, priority_level,
        output ready
    );
endinterface

>>> src/epot_out_if.sv
// ----------------------------------------------------------------------------
// epot_out_if: result channel of the override table
// One result beat per input beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface epot_out_if;
    logic                           valid;
    logic                           ready;
    logic [epot_pkg::RATE_W-1:0]    active_rate;
    logic [epot_pkg::CNT_OUT_W-1:0] active_count;
    logic [epot_pkg::DUR_W-1:0]     soonest_expiry;
    logic [epot_pkg::STAT_W-1:0]    status_code;

    modport source (
        output valid, active_rate, active_count, soonest_expiry, status_code,
        input  ready
    );
    modport sink (
        input  valid, active_rate, active_count, soonest_expiry, status_code,
        output ready
    );
endinterface

>>> src/epot_cell.sv
// ----------------------------------------------------------------------------
// epot_cell: one slot of the override table
// Holds one entry, ages it on a tick, lets it slide down into an empty
// lower neighbor while packing, and folds it into the running scan result
// that travels up the chain one cell per cycle.
// ----------------------------------------------------------------------------
module epot_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epot_pkg::t_cell_cmd i_cmd,
    input  epot_pkg::t_entry   i_load_entry,
    input  logic               i_lower_valid,
    input  logic               i_upper_moves,
    input  epot_pkg::t_entry   i_upper_entry,
    input  epot_pkg::t_scan    i_scan,
    output logic               o_valid,
    output logic               o_moves,
    output epot_pkg::t_entry   o_entry,
    output epot_pkg::t_scan    o_scan
);

    logic             r_valid;
    epot_pkg::t_entry r_entry;
    epot_pkg::t_scan  r_scan;
    epot_pkg::t_scan  n_scan;

    // An entry moves down only when the slot directly below it is empty.
    assign o_moves = i_cmd.pack && r_valid && !i_lower_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.tick) begin
            r_valid <= r_valid && (r_entry.remaining > 16'd1);
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_upper_moves) begin
            r_valid <= 1'b1;
        end else if (o_moves) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_entry.remaining <= r_entry.remaining - 16'd1;
        end else if (i_cmd.load) begin
            r_entry <= i_load_entry;
        end else if (i_upper_moves) begin
            r_entry <= i_upper_entry;
        end
    end

    // Higher index is newer, so an equal priority replaces the one below.
    always_comb begin
        n_scan = i_scan;
        if (r_valid) begin
            n_scan.found = 1'b1;
            n_scan.count = i_scan.count + epot_pkg::CNT_W'(1);
            if (!i_scan.found || (r_entry.prio >= i_scan.prio)) begin
                n_scan.prio = r_entry.prio;
                n_scan.rate = r_entry.rate;
            end
            if (!i_scan.found || (r_entry.remaining < i_scan.soonest)) begin
                n_scan.soonest = r_entry.remaining;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_scan  = r_scan;

endmodule

>>> src/expiring_priority_override_table.sv
// ----------------------------------------------------------------------------
// expiring_priority_override_table: table of timed rate overrides
// Keeps requests in arrival order, ages them on ticks and reports the
// winning rate, live count and soonest expiry after every beat.
// ----------------------------------------------------------------------------
// The block handles one beat at a time. An accepted beat updates the row of
// TABLE_DEPTH cells at once (a tick ages every cell, a request with a nonzero
// duration loads the top cell if that cell is empty), then the row packs so
// live entries slide down in order, then a scan result travels up the row one
// cell per cycle. The result is loaded into the output register once the scan
// is done and that register is empty or being read; only then is the next
// input beat taken. A waiting result beat stays in its output register
// while the next input beat is taken. The normal rate register may be
// written at any time the block is idle.
module expiring_priority_override_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    epot_in_if.sink                     i_in,
    epot_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [epot_pkg::RATE_W-1:0] i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PACK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int DEPTH = epot_pkg::TABLE_DEPTH;

    logic [epot_pkg::RATE_W-1:0]   r_normal_rate;
    logic [1:0]                    r_state;
    logic [epot_pkg::STEP_W-1:0]   r_step;
    logic [epot_pkg::STAT_W-1:0]   r_status;
    logic [epot_pkg::STAT_W-1:0]   n_status;

    logic                          r_out_valid;
    logic [epot_pkg::RATE_W-1:0]   r_out_rate;
    logic [epot_pkg::CNT_OUT_W-1:0] r_out_count;
    logic [epot_pkg::DUR_W-1:0]    r_out_soonest;
    logic [epot_pkg::STAT_W-1:0]   r_out_status;

    logic                w_accept;
    logic                w_is_req;
    logic                w_full;
    logic                w_do_load;
    logic                w_done_load;
    epot_pkg::t_entry    w_new_entry;
    epot_pkg::t_scan     w_final;

    logic                w_valid [DEPTH];
    logic                w_moves [DEPTH];
    epot_pkg::t_entry    w_entry [DEPTH];
    epot_pkg::t_scan     w_scan  [DEPTH];
    epot_pkg::t_cell_cmd w_cmd   [DEPTH];

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_req   = (i_in.operation == epot_pkg::OP_REQUEST);

    // The row is packed whenever the block is idle, so the top cell tells
    // whether the table is full.
    assign w_full    = w_valid[DEPTH-1];
    assign w_do_load = w_accept && w_is_req && (i_in.duration_ticks != '0) && !w_full;

    assign w_new_entry.rate      = i_in.rate_value;
    assign w_new_entry.prio      = i_in.priority_level;
    assign w_new_entry.remaining = i_in.duration_ticks;

    always_comb begin
        priority if (!w_is_req) begin
            n_status = epot_pkg::STATUS_OK;
        end else if (i_in.duration_ticks == '0) begin
            n_status = epot_pkg::STATUS_ZERO_DUR;
        end else if (w_full) begin
            n_status = epot_pkg::STATUS_FULL;
        end else begin
            n_status = epot_pkg::STATUS_OK;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic             w_lower_valid;
        logic             w_upper_moves;
        epot_pkg::t_entry w_upper_entry;
        epot_pkg::t_scan  w_scan_in;

        if (gi == 0) begin : g_bottom
            assign w_lower_valid = 1'b1;
            assign w_scan_in     = '0;
        end else begin : g_mid
            assign w_lower_valid = w_valid[gi-1];
            assign w_scan_in     = w_scan[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_top
            assign w_upper_moves = 1'b0;
            assign w_upper_entry = '0;
            assign w_cmd[gi].load = w_do_load;
        end else begin : g_below
            assign w_upper_moves = w_moves[gi+1];
            assign w_upper_entry = w_entry[gi+1];
            assign w_cmd[gi].load = 1'b0;
        end

        assign w_cmd[gi].tick = w_accept && !w_is_req;
        assign w_cmd[gi].pack = (r_state == ST_PACK);

        epot_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd[gi]),
            .i_load_entry  (w_new_entry),
            .i_lower_valid (w_lower_valid),
            .i_upper_moves (w_upper_moves),
            .i_upper_entry (w_upper_entry),
            .i_scan        (w_scan_in),
            .o_valid       (w_valid[gi]),
            .o_moves       (w_moves[gi]),
            .o_entry       (w_entry[gi]),
            .o_scan        (w_scan[gi])
        );
    end

    assign w_final     = w_scan[DEPTH-1];
    assign w_done_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_rate <= epot_pkg::NORMAL_RATE_RST;
        end else if (i_cfg_we) begin
            r_normal_rate <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_PACK;
                        r_step  <= '0;
                    end
                end
                ST_PACK: begin
                    if (r_step == epot_pkg::STEP_LAST) begin
                        r_state <= ST_SCAN;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + epot_pkg::STEP_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (r_step == epot_pkg::STEP_LAST) begin
                        r_state <= ST_DONE;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + epot_pkg::STEP_W'(1);
                    end
                end
                ST_DONE: begin
                    if (w_done_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_load) begin
            r_out_rate    <= w_final.found ? w_final.rate : r_normal_rate;
            r_out_count   <= epot_pkg::CNT_OUT_W'(w_final.count);
            r_out_soonest <= w_final.found ? w_final.soonest : '0;
            r_out_status  <= r_status;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.active_rate    = r_out_rate;
    assign o_out.active_count   = r_out_count;
    assign o_out.soonest_expiry = r_out_soonest;
    assign o_out.status_code    = r_out_status;

endmodule

>>> src/epot_chk.sv
// ----------------------------------------------------------------------------
// epot_chk: port checks for the override table
// Watches the handshakes and result fields seen at the top level ports.
// ----------------------------------------------------------------------------
module epot_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [epot_pkg::CNT_OUT_W-1:0] i_active_count,
    input logic [epot_pkg::DUR_W-1:0]     i_soonest_expiry,
    input logic [epot_pkg::STAT_W-1:0]    i_status_code
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Only one input beat is in the table logic at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a beat");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status_code <= epot_pkg::STATUS_FULL))
        else $error("undefined status code");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_active_count <= epot_pkg::CNT_OUT_W'(epot_pkg::TABLE_DEPTH)))
        else $error("live count above table depth");

    // Live entries always have at least one tick left.
    a_empty_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_active_count == '0) == (i_soonest_expiry == '0)))
        else $error("soonest expiry does not match live count");

endmodule

bind expiring_priority_override_table epot_chk u_epot_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_active_count   (o_out.active_count),
    .i_soonest_expiry (o_out.soonest_expiry),
    .i_status_code    (o_out.status_code)
);
